/* design/sidpe_pkg.sv */
// ----------------------------------------------------------------------------
// Stereo interleave delta pixel encoder package
// Pixel color and pixel decision types, and RGB565 packing, for the encoder modules.
// ----------------------------------------------------------------------------
package sidpe_pkg;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// Decision for one incoming pixel
	typedef struct packed {
		logic       keep;
		logic [7:0] disp;
		logic [7:0] row_flip;
	} sel_t;

	function automatic logic [15:0] pack565(input rgb_t p);
		return {p.red[7:3], p.green[7:2], p.blue[7:3]};
	endfunction

endpackage

/* design/stereo_interleave_delta_pixel_encoder.sv */
// ----------------------------------------------------------------------------
// Stereo interleave delta pixel encoder
// Merges a side-by-side stereo frame column by column, compares each merged
// pixel with the previous frame and emits changed pixels as RGB565.
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+-----------------------------------
//   pixel    | pixel_valid  | pixel_stall  | pixel_column pixel_row red green blue
//   result   | result_valid | result_stall | column row color565
//
// One pixel per cycle unless pixel_stall is high. Stages: frame store read,
// then compare and pack into the result register; the store is written as
// the pixel leaves the read stage, with a bypass for back-to-back hits on one
// address. After reset a clearing pass writes zero to all WIDTH*HEIGHT store
// entries, one per cycle; pixel_stall stays high until the pass ends.
// A stalled result holds the read stage, which then stalls the pixel side.
// ----------------------------------------------------------------------------
module stereo_interleave_delta_pixel_encoder
	import sidpe_pkg::*;
#(
	parameter int WIDTH  = 128,
	parameter int HEIGHT = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  logic [7:0]  pixel_column,
	input  logic [6:0]  pixel_row,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [6:0]  column,
	output logic [7:0]  row,
	output logic [15:0] color565
);

	localparam int DEPTH = WIDTH * HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	logic [23:0]   mem [DEPTH];

	sel_t          sel;
	logic [AW-1:0] sel_idx;
	rgb_t          pix_in;

	logic          clearing_q;
	logic [AW-1:0] clr_idx_q;

	logic          valid_s1;
	logic [AW-1:0] idx_s1;
	rgb_t          pix_s1;
	logic [7:0]    disp_s1;
	logic [7:0]    row_s1;
	logic [23:0]   rd_s1;
	logic          hit_s1;
	rgb_t          byp_s1;

	logic          result_valid_q;
	logic [6:0]    column_q;
	logic [7:0]    row_q;
	logic [15:0]   color_q;

	logic          accept;
	logic          can_move;
	logic          advance;
	rgb_t          prev_s1;
	logic          differs_s1;
	logic          we;
	logic [AW-1:0] waddr;
	logic [23:0]   wdata;

	sidpe_pixel_select #(
		.WIDTH  (WIDTH),
		.HEIGHT (HEIGHT),
		.AW     (AW)
	) u_select (
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.sel          (sel),
		.idx          (sel_idx)
	);

	assign pix_in      = '{red: red, green: green, blue: blue};
	assign can_move    = !result_valid_q || !result_stall;
	assign advance     = valid_s1 && can_move;
	assign pixel_stall = clearing_q || (valid_s1 && !can_move);
	assign accept      = pixel_valid && !pixel_stall;

	// take the pixel written in the same cycle as this read over the stale read
	assign prev_s1    = hit_s1 ? byp_s1 : rgb_t'(rd_s1);
	assign differs_s1 = prev_s1 != pix_s1;

	assign we    = clearing_q || advance;
	assign waddr = clearing_q ? clr_idx_q : idx_s1;
	assign wdata = clearing_q ? 24'd0 : pix_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (accept) begin
			rd_s1 <= mem[sel_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == LAST_IDX) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			hit_s1   <= 1'b0;
		end else if (accept) begin
			valid_s1 <= sel.keep;
			hit_s1   <= advance && (idx_s1 == sel_idx);
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1  <= sel_idx;
			pix_s1  <= pix_in;
			disp_s1 <= sel.disp;
			row_s1  <= sel.row_flip;
			byp_s1  <= pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (can_move) begin
			result_valid_q <= valid_s1 && differs_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			column_q <= disp_s1[6:0];
			row_q    <= row_s1;
			color_q  <= pack565(pix_s1);
		end
	end

	assign result_valid = result_valid_q;
	assign column       = column_q;
	assign row          = row_q;
	assign color565     = color_q;

`ifndef SYNTHESIS
	// no request reaches the store while it is being cleared, so no result is presented
	a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(clearing_q || $past(clearing_q)) |-> !result_valid)
		else $error("result presented during store clearing");

	// hold the read stage while a result waits
	a_hold_read_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && result_valid && result_stall) |=> (valid_s1 && $stable(idx_s1)))
		else $error("read stage lost a pixel under output stall");

	a_clear_ends_at_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing_q) |-> ($past(clr_idx_q) == LAST_IDX))
		else $error("clearing pass ended early");
`endif

endmodule

/* design/sidpe_pixel_select.sv */
// ----------------------------------------------------------------------------
// Stereo interleave delta pixel encoder - pixel select
// Picks left-view even columns and right-view odd columns, flips the row
// and forms the linear address of the merged pixel in the frame store.
// ----------------------------------------------------------------------------
module sidpe_pixel_select
	import sidpe_pkg::*;
#(
	parameter int WIDTH  = 128,
	parameter int HEIGHT = 128,
	parameter int AW     = 14
) (
	input  logic [7:0]    pixel_column,
	input  logic [6:0]    pixel_row,
	output sel_t          sel,
	output logic [AW-1:0] idx
);

	localparam logic [9:0] WIDTH10  = 10'(WIDTH);
	localparam logic [9:0] WIDTH2   = 10'(2 * WIDTH);
	localparam logic [7:0] HEIGHT8  = 8'(HEIGHT);

	logic [9:0]  col10;
	logic [9:0]  right_off;
	logic        row_ok;
	logic        left_keep;
	logic        right_keep;
	logic [31:0] lin;

	assign col10      = {2'b00, pixel_column};
	assign right_off  = col10 - WIDTH10;
	assign row_ok     = {1'b0, pixel_row} < HEIGHT8;
	assign left_keep  = (col10 < WIDTH10) && !pixel_column[0];
	assign right_keep = (col10 >= WIDTH10) && (col10 < WIDTH2) && right_off[0];

	always_comb begin
		sel.keep     = row_ok && (left_keep || right_keep);
		sel.disp     = left_keep ? pixel_column : right_off[7:0];
		sel.row_flip = HEIGHT8 - {1'b0, pixel_row};
	end

	assign lin = 32'(pixel_row) * 32'(WIDTH) + 32'(sel.disp);
	assign idx = lin[AW-1:0];

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// Stereo interleave delta pixel encoder testbench
// Sends stereo pixels into the encoder with random gaps and result stalls.
// A local copy of the merged frame store predicts every changed pixel, and
// each emitted column, flipped row and RGB565 color is checked in order.
// ----------------------------------------------------------------------------
module tb_top;
	import sidpe_pkg::*;

	localparam int WIDTH  = 128;
	localparam int HEIGHT = 128;

	typedef struct packed {
		logic [6:0]  column;
		logic [7:0]  row;
		logic [15:0] color565;
	} delta_t;

	class delta_scoreboard #(int W = 128, int H = 128);
		rgb_t   frame_store [W*H];
		delta_t pending_deltas [$];
		int     mismatches;

		function new();
			foreach (frame_store[i])
				frame_store[i] = '0;
			mismatches = 0;
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			mismatches++;
		endtask

		// Display column of a merged pixel, or -1 when the pixel is dropped
		function int display_column(logic [7:0] col, logic [6:0] prow);
			if (prow >= H)
				return -1;
			if (col < W)
				return col[0] ? -1 : int'(col);
			if (col < 2 * W)
				return ((int'(col) - W) % 2 == 1) ? int'(col) - W : -1;
			return -1;
		endfunction

		function rgb_t stored_color(int disp, int prow);
			return frame_store[prow * W + disp];
		endfunction

		function int pending();
			return pending_deltas.size();
		endfunction

		function void note_pixel(logic [7:0] col, logic [6:0] prow, rgb_t px);
			int     disp;
			int     addr;
			delta_t d;
			disp = display_column(col, prow);
			if (disp < 0)
				return;
			addr = int'(prow) * W + disp;
			if (frame_store[addr] != px) begin
				d.column   = disp[6:0];
				d.row      = 8'(H - int'(prow));
				d.color565 = {px.red[7:3], px.green[7:2], px.blue[7:3]};
				pending_deltas.push_back(d);
			end
			// the store takes every merged pixel, changed or not
			frame_store[addr] = px;
		endfunction

		task check_result(delta_t got);
			delta_t want;
			if (pending_deltas.size() == 0) begin
				report_mismatch($sformatf("unexpected result column %0d row %0d color %h",
					got.column, got.row, got.color565));
				return;
			end
			want = pending_deltas.pop_front();
			if (got.column !== want.column || got.row !== want.row ||
					got.color565 !== want.color565)
				report_mismatch($sformatf(
					"column %0d/%0d row %0d/%0d color %h/%h (got/expected)",
					got.column, want.column, got.row, want.row,
					got.color565, want.color565));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        pixel_valid;
	logic        pixel_stall;
	logic [7:0]  pixel_column;
	logic [6:0]  pixel_row;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        result_valid;
	logic        result_stall;
	logic [6:0]  column;
	logic [7:0]  row;
	logic [15:0] color565;

	int tx_idle_pct;
	int rx_stall_pct;
	int hold_left;

	delta_scoreboard #(WIDTH, HEIGHT) sb;

	stereo_interleave_delta_pixel_encoder #(
		.WIDTH(WIDTH),
		.HEIGHT(HEIGHT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel_column(pixel_column),
		.pixel_row(pixel_row),
		.red(red),
		.green(green),
		.blue(blue),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.column(column),
		.row(row),
		.color565(color565)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_valid && !pixel_stall)
				sb.note_pixel(pixel_column, pixel_row, rgb_t'({red, green, blue}));
			if (result_valid && !result_stall)
				sb.check_result(delta_t'({column, row, color565}));
		end
	end

	// Result side: random stalls, or a counted hold-off when one is requested
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(99) < rx_stall_pct);
			end
		end
	end

	// Called just after a falling edge; returns just after one
	task automatic drive_pixel(logic [7:0] col, logic [6:0] prow, rgb_t px);
		while ($urandom_range(99) < tx_idle_pct) begin
			pixel_valid <= 1'b0;
			@(negedge clk);
		end
		pixel_valid  <= 1'b1;
		pixel_column <= col;
		pixel_row    <= prow;
		red          <= px.red;
		green        <= px.green;
		blue         <= px.blue;
		do
			@(posedge clk);
		while (pixel_stall);
		@(negedge clk);
	endtask

	// Drop the request and hold until every predicted result has come out
	task automatic drain();
		pixel_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	task automatic send_directed();
		drive_pixel(8'd0, 7'd0, rgb_t'(24'h000000));    // equals cleared store
		drive_pixel(8'd0, 7'd0, rgb_t'(24'hFFFFFF));
		drive_pixel(8'd0, 7'd0, rgb_t'(24'hFFFFFF));    // unchanged
		drive_pixel(8'd0, 7'd0, rgb_t'(24'h070307));    // changed, packs to zero
		drive_pixel(8'd1, 7'd5, rgb_t'(24'hFFFFFF));    // odd left column, dropped
		drive_pixel(8'd127, 7'd127, rgb_t'(24'h123456));
		drive_pixel(8'd126, 7'd127, rgb_t'(24'h800000));
		drive_pixel(8'd128, 7'd10, rgb_t'(24'hFFFFFF)); // even right offset, dropped
		drive_pixel(8'd129, 7'd10, rgb_t'(24'h00FF00));
		drive_pixel(8'd255, 7'd127, rgb_t'(24'hFFFFFF));
		drive_pixel(8'd255, 7'd127, rgb_t'(24'hFFFFFF));
		drive_pixel(8'd254, 7'd64, rgb_t'(24'h0000FF));
		// back to back on one address
		drive_pixel(8'd2, 7'd64, rgb_t'(24'hAA5533));
		drive_pixel(8'd2, 7'd64, rgb_t'(24'h55AACC));
		drive_pixel(8'd2, 7'd64, rgb_t'(24'h55AACC));
		drive_pixel(8'd2, 7'd64, rgb_t'(24'h000000));
		// one channel at a time
		drive_pixel(8'd4, 7'd1, rgb_t'(24'h010000));
		drive_pixel(8'd4, 7'd1, rgb_t'(24'h010100));
		drive_pixel(8'd4, 7'd1, rgb_t'(24'h010101));
		drive_pixel(8'd131, 7'd127, rgb_t'(24'h5A5AA5));
	endtask

	task automatic send_random(int kept_target);
		int         kept;
		int         kind;
		int         disp;
		logic [7:0] col;
		logic [6:0] prow;
		rgb_t       px;
		kept = 0;
		col  = '0;
		prow = '0;
		px   = '0;
		while (kept < kept_target) begin
			kind = $urandom_range(99);
			if (kind < 10) begin
				// same address again, often the same color
				if ($urandom_range(1) == 0)
					px = rgb_t'($urandom);
			end else if (kind < 25) begin
				col  = 8'($urandom_range(255));
				prow = 7'($urandom_range(127));
				px   = rgb_t'($urandom);
			end else begin
				if (kind < 55) begin
					// small patch so that pixels are revisited
					disp = $urandom_range(7);
					prow = 7'($urandom_range(3));
					case ($urandom_range(3))
						0, 1: px = sb.stored_color(disp, prow);
						2: px = rgb_t'($urandom);
						default: px = sb.stored_color(disp, prow) ^ rgb_t'(24'h070307 & $urandom);
					endcase
				end else begin
					disp = $urandom_range(WIDTH - 1);
					prow = 7'($urandom_range(HEIGHT - 1));
					px   = rgb_t'($urandom);
				end
				col = disp[0] ? 8'(WIDTH + disp) : 8'(disp);
			end
			drive_pixel(col, prow, px);
			if (sb.display_column(col, prow) >= 0)
				kept++;
		end
	endtask

	initial begin
		int n;
		sb           = new();
		arst_n       = 1'b0;
		pixel_valid  = 1'b0;
		pixel_column = '0;
		pixel_row    = '0;
		red          = '0;
		green        = '0;
		blue         = '0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_left    = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_directed();
		drain();
		@(negedge clk);

		tx_idle_pct  = 19;
		rx_stall_pct = 68;
		send_random(300);
		drain();
		@(negedge clk);

		tx_idle_pct  = 68;
		rx_stall_pct = 19;
		send_random(300);
		drain();

		// hold results off while requests keep coming, so the block backs up
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_left    = 50;
		@(negedge clk);
		send_random(30);
		send_random(300);
		pixel_valid <= 1'b0;

		for (n = 0; n < 5000 && sb.pending() != 0; n++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d expected results never arrived",
				sb.pending()));
		if (sb.mismatches == 0) begin
			$display("stereo_interleave_delta_pixel_encoder regression: pass");
		end else begin
			$display("stereo_interleave_delta_pixel_encoder regression: fail");
		end
		$finish;
	end

	// Clearing pass after reset plus the whole run fits well inside this
	initial begin
		#3000000;
		$display("stereo_interleave_delta_pixel_encoder regression: fail");
		$finish;
	end

endmodule
